// ===== hw/rtl/bitmap_slot_allocator_assert.svh =====
// assertion macros for the bitmap slot allocator
// no dependencies; included by the top level before its checks
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication check
`define BSA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap slot allocator: same-cycle check failed");

// next-cycle implication check
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap slot allocator: next-cycle check failed");

`endif

// ===== hw/rtl/bsa_pkg.sv =====
// shared types, sizes and helper functions of the bitmap slot allocator
// no dependencies
`timescale 1ns / 1ps

package bsa_pkg;

   // store geometry
   localparam int NUM_BUCKETS = 8;
   localparam int BUCKET_SIZE = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int TOTAL_SLOTS = NUM_BUCKETS * BUCKET_SIZE;

   // fixed field widths of the transactions
   localparam int BUCKET_W  = 3;
   localparam int SLOT_W    = 4;
   localparam int ELEMENT_W = 32;
   localparam int COUNT_W   = 8;

   // internal widths
   localparam int INDEX_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int POS_W   = $clog2(TOTAL_SLOTS + 1);

   typedef logic [TOTAL_SLOTS-1:0] bitmap_type;
   typedef logic [INDEX_W-1:0]     index_type;
   typedef logic [POS_W-1:0]       pos_type;
   typedef logic [DATA_WIDTH-1:0]  entry_type;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_REMOVE = 2'd1,
      FN_GET    = 2'd2,
      FN_SEEK   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_FREE = 2'd2,
      ST_NONE = 2'd3
   } status_type;

   typedef struct packed {
      func_type              func;
      logic [ELEMENT_W-1:0]  element;
      logic [BUCKET_W-1:0]   bucket;
      logic [SLOT_W-1:0]     slot;
      logic                  from_start;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [BUCKET_W-1:0]   out_bucket;
      logic [SLOT_W-1:0]     out_slot;
      logic [ELEMENT_W-1:0]  data;
      logic [COUNT_W-1:0]    occupied_count;
   } rsp_type;

   // outcome of one transaction, from the bitmap to the top level
   typedef struct packed {
      status_type status;
      index_type  index;
      logic       write_entry;
      logic       read_entry;
   } decide_type;

   typedef struct packed {
      logic      found;
      index_type index;
   } hit_type;

   // lowest set bit of a bitmap: isolate it, then encode the one-hot word
   function automatic hit_type first_set(input bitmap_type vec);
      bitmap_type lowest;
      hit_type    hit;
      lowest    = vec & (~vec + 1'b1);
      hit.found = |vec;
      hit.index = '0;
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
         if (lowest[i]) begin
            hit.index = hit.index | INDEX_W'(i);
         end
      end
      return hit;
   endfunction

endpackage

// ===== hw/rtl/bsa_entry_ram.sv =====
// element store of the bitmap slot allocator: one write and one registered read port
// depends on bsa_pkg
`timescale 1ns / 1ps

module bsa_entry_ram (
   input  logic              clock,
   input  logic              wr_en,
   input  bsa_pkg::index_type wr_index,
   input  bsa_pkg::entry_type wr_data,
   input  logic              rd_en,
   input  bsa_pkg::index_type rd_index,
   output bsa_pkg::entry_type rd_data
);

   bsa_pkg::entry_type mem [bsa_pkg::TOTAL_SLOTS];
   bsa_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_index] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_index];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bsa_bitmap.sv =====
// occupancy bitmap, live count and slot search of the bitmap slot allocator
// depends on bsa_pkg
`timescale 1ns / 1ps

module bsa_bitmap (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  bsa_pkg::req_type              req,
   output bsa_pkg::decide_type           decide,
   output logic [bsa_pkg::COUNT_W-1:0]   count
);

   bsa_pkg::bitmap_type              occupancy_ff, occupancy_in;
   logic [bsa_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             in_range;
   bsa_pkg::index_type               loc_index;
   bsa_pkg::pos_type                 start;
   bsa_pkg::bitmap_type              seek_mask;
   bsa_pkg::hit_type                 free_hit, seek_hit;
   bsa_pkg::decide_type              decide_c;

   // locator decode
   always_comb begin
      in_range  = (int'(req.bucket) < bsa_pkg::NUM_BUCKETS) &&
                  (int'(req.slot) < bsa_pkg::BUCKET_SIZE);
      loc_index = bsa_pkg::INDEX_W'(int'(req.bucket) * bsa_pkg::BUCKET_SIZE +
                                    int'(req.slot));
   end

   // first position a seek may return
   always_comb begin
      if (req.from_start) begin
         start = '0;
      end else if (int'(req.bucket) >= bsa_pkg::NUM_BUCKETS) begin
         start = bsa_pkg::POS_W'(bsa_pkg::TOTAL_SLOTS);
      end else if (int'(req.slot) >= bsa_pkg::BUCKET_SIZE) begin
         start = bsa_pkg::POS_W'((int'(req.bucket) + 1) * bsa_pkg::BUCKET_SIZE);
      end else begin
         start = bsa_pkg::POS_W'(int'(req.bucket) * bsa_pkg::BUCKET_SIZE +
                                 int'(req.slot) + 1);
      end
      for (int i = 0; i < bsa_pkg::TOTAL_SLOTS; i++) begin
         seek_mask[i] = (bsa_pkg::POS_W'(i) >= start);
      end
   end

   // priority search for a free slot and for the next occupied one
   always_comb begin
      free_hit = bsa_pkg::first_set(~occupancy_ff);
      seek_hit = bsa_pkg::first_set(occupancy_ff & seek_mask);
   end

   // decision and next bitmap state
   always_comb begin
      decide_c.status      = bsa_pkg::ST_OK;
      decide_c.index       = '0;
      decide_c.write_entry = 1'b0;
      decide_c.read_entry  = 1'b0;
      occupancy_in         = occupancy_ff;
      count_in             = count_ff;
      case (req.func)
         bsa_pkg::FN_ADD: begin
            if (free_hit.found) begin
               decide_c.index                = free_hit.index;
               decide_c.write_entry          = 1'b1;
               occupancy_in[free_hit.index]  = 1'b1;
               count_in                      = count_ff + bsa_pkg::COUNT_W'(1);
            end else begin
               decide_c.status = bsa_pkg::ST_FULL;
            end
         end
         bsa_pkg::FN_REMOVE, bsa_pkg::FN_GET: begin
            if (in_range && occupancy_ff[loc_index]) begin
               decide_c.index      = loc_index;
               decide_c.read_entry = 1'b1;
               if (req.func == bsa_pkg::FN_REMOVE) begin
                  occupancy_in[loc_index] = 1'b0;
                  count_in                = count_ff - bsa_pkg::COUNT_W'(1);
               end
            end else begin
               decide_c.status = bsa_pkg::ST_FREE;
            end
         end
         bsa_pkg::FN_SEEK: begin
            if (seek_hit.found) begin
               decide_c.index      = seek_hit.index;
               decide_c.read_entry = 1'b1;
            end else begin
               decide_c.status = bsa_pkg::ST_NONE;
            end
         end
         default: begin
            decide_c.status = bsa_pkg::ST_NONE;
         end
      endcase
   end

   // state update, once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
         count_ff     <= '0;
      end else if (advance) begin
         occupancy_ff <= occupancy_in;
         count_ff     <= count_in;
      end
   end

   assign decide = decide_c;
   assign count  = count_ff;

endmodule

// ===== hw/rtl/bitmap_slot_allocator.sv =====
// Bitmap slot allocator: 8 buckets of 16 slots, each holding a 32-bit element, with
// one occupancy bit per slot. Add fills the first free slot in bucket-then-slot order,
// remove and get act on a given locator, seek finds the next occupied slot. One
// transaction is accepted every cycle while responses are taken. A transaction goes
// through the input register and then the result register. A response left waiting
// holds the transaction behind it in the input register, and the input then stalls
// until the response is taken. The priority encoders over the occupancy bitmap and
// the single read port of the element RAM each serve one transaction per cycle while
// responses are taken. The occupancy map is cleared by reset; no clearing pass.
// depends on bsa_pkg, bsa_bitmap, bsa_entry_ram and bitmap_slot_allocator_assert.svh
`timescale 1ns / 1ps

`include "bitmap_slot_allocator_assert.svh"

module bitmap_slot_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsa_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsa_pkg::rsp_type rsp_payload
);

   logic                          in_valid_ff, in_valid_in;
   bsa_pkg::req_type              in_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   bsa_pkg::status_type           status_ff;
   bsa_pkg::index_type            index_ff;
   logic                          from_ram_ff;
   bsa_pkg::entry_type            element_ff;
   logic                          advance;
   logic                          req_take;
   bsa_pkg::decide_type           decide;
   logic [bsa_pkg::COUNT_W-1:0]   count;
   bsa_pkg::entry_type            rd_data;
   logic                          rsp_ok;
   logic                          full_rsp;
   logic                          count_full;
   logic                          err_rsp;
   logic                          err_zero;
   logic                          rsp_stall;

   // handshake: process when the result register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_payload;
      end
   end

   // bitmap, count and search
   bsa_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_ff),
      .decide  (decide),
      .count   (count)
   );

   // element store
   bsa_entry_ram u_entry_ram (
      .clock    (clock),
      .wr_en    (advance && decide.write_entry),
      .wr_index (decide.index),
      .wr_data  (bsa_pkg::DATA_WIDTH'(in_ff.element)),
      .rd_en    (advance && decide.read_entry),
      .rd_index (decide.index),
      .rd_data  (rd_data)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff   <= decide.status;
         index_ff    <= decide.index;
         from_ram_ff <= decide.read_entry;
         element_ff  <= bsa_pkg::DATA_WIDTH'(in_ff.element);
      end
   end

   // response assembly: locator and data read as zero unless the status is ok
   assign rsp_ok = (status_ff == bsa_pkg::ST_OK);

   always_comb begin
      rsp_payload.status         = status_ff;
      rsp_payload.out_bucket     = '0;
      rsp_payload.out_slot       = '0;
      rsp_payload.data           = '0;
      rsp_payload.occupied_count = count;
      if (rsp_ok) begin
         rsp_payload.out_bucket = bsa_pkg::BUCKET_W'(index_ff / bsa_pkg::BUCKET_SIZE);
         rsp_payload.out_slot   = bsa_pkg::SLOT_W'(index_ff % bsa_pkg::BUCKET_SIZE);
         rsp_payload.data       = from_ram_ff ? bsa_pkg::ELEMENT_W'(rd_data)
                                              : bsa_pkg::ELEMENT_W'(element_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // terms for the checks
   assign full_rsp   = rsp_valid_ff && (status_ff == bsa_pkg::ST_FULL);
   assign count_full = (int'(count) == bsa_pkg::TOTAL_SLOTS);
   assign err_rsp    = rsp_valid_ff && !rsp_ok;
   assign err_zero   = (rsp_payload.out_bucket == '0) && (rsp_payload.out_slot == '0) &&
                       (rsp_payload.data == '0);
   assign rsp_stall  = in_valid_ff && rsp_valid_ff && !rsp_ready;

   // checks
   `BSA_ASSERT_IMPLIES(a_full_count, clock, reset, full_rsp, count_full)
   `BSA_ASSERT_IMPLIES(a_err_zero, clock, reset, err_rsp, err_zero)
   `BSA_ASSERT_IMPLIES(a_stall_blocks, clock, reset, rsp_stall, !req_ready)
   `BSA_ASSERT_NEXT(a_advance_result, clock, reset, advance, rsp_valid_ff)

endmodule
